[design/lrc_pkg.sv]
// Shared types and constants for the LRU cache table.
// Used by lrc_cell and lru_cache_table; depends on nothing else.
package lrc_pkg;

    localparam int CAPACITY    = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int OCC_WIDTH   = 7;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // One stored entry as it moves from cell to cell.
    typedef struct packed {
        logic                   valid;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } entry_t;

    // Match result gathered from the tail of the row toward the head.
    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] value;
    } probe_t;

    // Per-transfer controls broadcast to every cell.
    typedef struct packed {
        logic step;
        logic clear;
        logic shift_all;
        logic hit_any;
    } cell_ctl_t;

endpackage

[design/lrc_cell.sv]
// One position of the recency stack: holds a single entry and compares it
// against the broadcast key. Depends on lrc_pkg.
module lrc_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrc_pkg::cell_ctl_t              ctl,
    input  logic [lrc_pkg::KEY_WIDTH-1:0]   key,
    input  lrc_pkg::entry_t                 prev_entry,
    output lrc_pkg::entry_t                 entry,
    input  lrc_pkg::probe_t                 probe_in,
    output lrc_pkg::probe_t                 probe_out
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [lrc_pkg::KEY_WIDTH-1:0]     key_reg;
    logic [lrc_pkg::VALUE_WIDTH-1:0]   value_reg;
    logic                              match;
    logic                              load;

    assign match = valid_reg && (key_reg == key);

    // Keys are unique among valid entries, so at most one cell matches.
    assign probe_out.hit   = probe_in.hit | match;
    assign probe_out.value = probe_in.value | (match ? value_reg : '0);

    // A cell takes its neighbor's entry on a new insert, or when the hit
    // entry sits here or further toward the tail (it moves to the head).
    assign load = ctl.step && (ctl.shift_all || (ctl.hit_any && probe_out.hit));

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.step && ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (load)
        begin
            valid_next = prev_entry.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !ctl.clear)
        begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

[design/lru_cache_table.sv]
// Top level of the LRU cache table: a row of lrc_cell positions plus the
// command decode, entry counter and output register. Depends on lrc_pkg.
//
// Fully associative key/value store with least-recently-used replacement,
// kept as a recency-ordered row of cells: the head cell holds the most recent
// entry, the tail cell the least recent. For each command (lookup, insert, clear)
// all cells compare the key at once; a hit, or a new entry on an insert miss, is
// written into the head and the cells in front of it shift one place toward the
// tail, so the least recent entry drops off the tail when the store is full; a
// clear empties every cell. A new command is accepted every cycle as long as the
// result register is empty or being read in the same cycle; the result appears
// the cycle after the input transfer. There is no clearing pass after reset.
module lru_cache_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    input  logic [31:0] value_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] value_out,
    output logic        full_res,
    output logic [6:0]  occupancy
);

    localparam int CAP = lrc_pkg::CAPACITY;

    lrc_pkg::entry_t                    entry_q [CAP];
    lrc_pkg::probe_t                    probe_q [CAP+1];
    lrc_pkg::entry_t                    head_entry;
    lrc_pkg::cell_ctl_t                 ctl;
    lrc_pkg::cmd_t                      cmd_code;
    logic                               accept;
    logic                               is_search;

    logic [lrc_pkg::COUNT_WIDTH-1:0]    count_reg;
    logic [lrc_pkg::COUNT_WIDTH-1:0]    count_next;
    logic                               out_valid_reg;
    logic                               hit_reg;
    logic [lrc_pkg::VALUE_WIDTH-1:0]    value_out_reg;
    logic                               full_reg;
    logic [lrc_pkg::COUNT_WIDTH-1:0]    occ_reg;

    assign cmd_code  = lrc_pkg::cmd_t'(cmd);
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_search = (cmd_code == lrc_pkg::CMD_LOOKUP) || (cmd_code == lrc_pkg::CMD_INSERT);

    assign probe_q[CAP] = '0;

    assign ctl.step      = accept;
    assign ctl.clear     = (cmd_code == lrc_pkg::CMD_CLEAR);
    assign ctl.hit_any   = is_search && probe_q[0].hit;
    assign ctl.shift_all = (cmd_code == lrc_pkg::CMD_INSERT) && !probe_q[0].hit;

    // On a hit the matched entry moves to the head with its old value.
    assign head_entry.valid = 1'b1;
    assign head_entry.key   = key;
    assign head_entry.value = probe_q[0].hit ? probe_q[0].value : value_in;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lrc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key),
                .prev_entry (head_entry),
                .entry      (entry_q[i]),
                .probe_in   (probe_q[i+1]),
                .probe_out  (probe_q[i])
            );
        end
        else
        begin : g_body
            lrc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key),
                .prev_entry (entry_q[i-1]),
                .entry      (entry_q[i]),
                .probe_in   (probe_q[i+1]),
                .probe_out  (probe_q[i])
            );
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.shift_all && (count_reg != lrc_pkg::COUNT_WIDTH'(CAP)))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg       <= ctl.hit_any;
            value_out_reg <= ((cmd_code == lrc_pkg::CMD_LOOKUP) && probe_q[0].hit)
                             ? probe_q[0].value : '0;
            full_reg      <= (count_next == lrc_pkg::COUNT_WIDTH'(CAP));
            occ_reg       <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign value_out = value_out_reg;
    assign full_res  = full_reg;
    assign occupancy = lrc_pkg::OCC_WIDTH'(occ_reg);

    // A full store has a valid entry in the tail cell.
    a_full_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == lrc_pkg::COUNT_WIDTH'(CAP)) |-> entry_q[CAP-1].valid)
        else $error("full store without a valid tail entry");

    // An empty store has no valid entry at the head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !entry_q[0].valid)
        else $error("empty store with a valid head entry");

    // A clear transfer leaves the store empty.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.clear) |=> (count_reg == '0))
        else $error("clear did not empty the store");

    // A reported hit needs at least one entry.
    a_hit_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (occ_reg != '0))
        else $error("hit reported with zero occupancy");

endmodule
